// ----- rtl/core/point_extent_and_kde_bandwidth_defines.svh -----
// ----------------------------------------------------------------------------
// Point extent and KDE bandwidth: assertion macros
// Shared assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef POINT_EXTENT_AND_KDE_BANDWIDTH_DEFINES_SVH
`define POINT_EXTENT_AND_KDE_BANDWIDTH_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEKB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PEKB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pekb_pkg.sv -----
// ----------------------------------------------------------------------------
// pekb_pkg
// Types, widths and register codes shared by the extent and bandwidth block.
// ----------------------------------------------------------------------------
package pekb_pkg;

  localparam int unsigned COORD_W    = 24;
  localparam int unsigned CNT_W      = 17;
  localparam int unsigned MAX_POINTS = 65536;
  localparam int unsigned SUM_W      = 40;
  localparam int unsigned SQ_W       = 64;
  localparam int unsigned BW_W       = 40;
  localparam int unsigned BW_SHIFT   = 24;
  localparam int unsigned SCALE_W    = 16;
  localparam int unsigned GRID_W     = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;
  localparam logic [GRID_W-1:0]  ROWS_RST  = 11'd16;
  localparam logic [GRID_W-1:0]  COLS_RST  = 11'd32;

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Shared multiply-accumulate unit.
  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned MAC_A_W   = 96;
  localparam int unsigned MAC_B_W   = 64;
  localparam int unsigned MAC_ACC_W = 128;

  // Serial divider and square root.
  localparam int unsigned DIV_N_W   = 82;
  localparam int unsigned DIV_D_W   = 32;
  localparam int unsigned DIV_Q_W   = 64;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_N_W + 1);
  localparam int unsigned ROOT_IN_W = DIV_Q_W;
  localparam int unsigned ROOT_W    = ROOT_IN_W / 2;

  // Inverse sixth root search: g^6 * n <= 2^G_LIM_BIT.
  localparam int unsigned G_W       = 16;
  localparam int unsigned G_K_W     = $clog2(G_W);
  localparam int unsigned G_LIM_BIT = 96;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } pekb_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_x;
    logic signed [COORD_W-1:0] max_x;
    logic signed [COORD_W-1:0] min_y;
    logic signed [COORD_W-1:0] max_y;
    logic [COORD_W-1:0]        step_x;
    logic [COORD_W-1:0]        step_y;
    logic [BW_W-1:0]           bandwidth;
    logic [CNT_W-1:0]          point_count;
    logic                      too_few_points;
  } pekb_out_t;

  typedef struct packed {
    logic [CNT_W-1:0]          count;
    logic signed [COORD_W-1:0] lo_x;
    logic signed [COORD_W-1:0] hi_x;
    logic signed [COORD_W-1:0] lo_y;
    logic signed [COORD_W-1:0] hi_y;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    logic [SQ_W-1:0]           sumsq_x;
    logic [SQ_W-1:0]           sumsq_y;
  } pekb_acc_t;

  typedef struct packed {
    logic               start;
    logic               clr;
    logic               sub;
    logic [1:0]         na;
    logic [1:0]         nb;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
  } pekb_mac_req_t;

endpackage

// ----- rtl/core/point_extent_and_kde_bandwidth.sv -----
// A point without the last mark is taken while idle, and such points follow back to back.
// After a last point the block runs three divides on the shared divider, a root,
// and a 16-step inverse sixth root search on the shared multiplier.
// With fewer than two points only the grid steps are computed and the bandwidth is zero.
// The finished item waits in an output register while the next set streams in.
// Reset (rst_ni low, asynchronous) restores the registers and clears the set.
// ----------------------------------------------------------------------------
// point_extent_and_kde_bandwidth
// Bounding box, grid steps and Scott's-rule kernel bandwidth of a 2-D point set.
// ----------------------------------------------------------------------------
module point_extent_and_kde_bandwidth import pekb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  pekb_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output pekb_out_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCALE_W-1:0]   cfg_wdata_i
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_STEPX = 17'h00002,
    S_STEPY = 17'h00004,
    S_NN    = 17'h00008,
    S_QX    = 17'h00010,
    S_SX    = 17'h00020,
    S_QY    = 17'h00040,
    S_SY    = 17'h00080,
    S_VAR   = 17'h00100,
    S_ROOT  = 17'h00200,
    S_P2    = 17'h00400,
    S_P4    = 17'h00800,
    S_P6    = 17'h01000,
    S_PN    = 17'h02000,
    S_BW1   = 17'h04000,
    S_BW2   = 17'h08000,
    S_OUT   = 17'h10000
  } seq_state_e;

  seq_state_e state_q, state_d;
  logic       launched_q, launched_d;
  logic       out_valid_q;

  logic [SCALE_W-1:0] scale_q;
  logic [GRID_W-1:0]  rows_q, cols_q;

  logic [COORD_W-1:0] step_x_q, step_x_d, step_y_q, step_y_d;
  logic [DIV_D_W-1:0] den_q, den_d;
  logic [G_W-1:0]     g_q, g_d, cand;
  logic [G_K_W-1:0]   k_q, k_d;
  logic [LIMB_W-1:0]  p2_q, p2_d;
  logic [ROOT_W-1:0]  root_q, root_d;
  logic [BW_W-1:0]    bw_q, bw_d;
  pekb_out_t          out_q, out_d;

  pekb_acc_t            acc;
  logic                 in_take, acc_clr, out_load;
  pekb_mac_req_t        mac_req;
  logic                 mac_done;
  logic [MAC_ACC_W-1:0] mac_acc;
  logic                 div_start, div_done;
  logic [DIV_N_W-1:0]   div_num;
  logic [DIV_D_W-1:0]   div_den;
  logic [DIV_Q_W-1:0]   div_quo;
  logic                 sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]    sqrt_root;

  logic [CNT_W-1:0]   n;
  logic               few, ok_x, ok_y, pn_ok, bw_sat;
  logic [COORD_W-1:0] dx, dy;
  logic [SUM_W-1:0]   mag_sx, mag_sy;

  assign in_stall_o = state_q != S_IDLE;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      rows_q  <= ROWS_RST;
      cols_q  <= COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SCALE: scale_q <= cfg_wdata_i;
        CFG_ROWS:  rows_q  <= cfg_wdata_i[GRID_W-1:0];
        CFG_COLS:  cols_q  <= cfg_wdata_i[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  pekb_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (in_take),
    .clr_i  (acc_clr),
    .x_i    (in_data_i.point_x),
    .y_i    (in_data_i.point_y),
    .acc_o  (acc)
  );

  pekb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mac_req),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  pekb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  pekb_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (div_quo),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  always_comb begin
    n      = acc.count;
    few    = n < CNT_W'(2);
    ok_x   = (rows_q > GRID_W'(1)) && (acc.hi_x >= acc.lo_x);
    ok_y   = (cols_q > GRID_W'(1)) && (acc.hi_y >= acc.lo_y);
    dx     = COORD_W'(acc.hi_x - acc.lo_x);
    dy     = COORD_W'(acc.hi_y - acc.lo_y);
    mag_sx = acc.sum_x[SUM_W-1] ? SUM_W'(-acc.sum_x) : SUM_W'(acc.sum_x);
    mag_sy = acc.sum_y[SUM_W-1] ? SUM_W'(-acc.sum_y) : SUM_W'(acc.sum_y);
    cand   = g_q | (G_W'(1) << k_q);
    // Candidate passes when g^6 * n is at most 2^96.
    pn_ok  = (mac_acc[MAC_ACC_W-1:G_LIM_BIT+1] == '0) &&
             (!mac_acc[G_LIM_BIT] || (mac_acc[G_LIM_BIT-1:0] == '0));
    bw_sat = |mac_acc[MAC_ACC_W-1:BW_SHIFT+BW_W];
  end

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    step_x_d   = step_x_q;
    step_y_d   = step_y_q;
    den_d      = den_q;
    g_d        = g_q;
    k_d        = k_q;
    p2_d       = p2_q;
    root_d     = root_q;
    bw_d       = bw_q;
    out_d      = out_q;
    mac_req    = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    sqrt_start = 1'b0;
    acc_clr    = 1'b0;
    out_load   = 1'b0;

    mac_req.start = !launched_q;

    unique case (state_q)
      S_IDLE: begin
        mac_req.start = 1'b0;
        if (in_take && in_data_i.last_point) begin
          state_d    = S_STEPX;
          launched_d = 1'b0;
        end
      end
      S_STEPX: begin
        mac_req.start = 1'b0;
        div_num = DIV_N_W'(dx);
        div_den = DIV_D_W'(rows_q - 1'b1);
        if (!ok_x) begin
          step_x_d = '0;
          state_d  = S_STEPY;
        end else if (!launched_q) begin
          div_start  = 1'b1;
          launched_d = 1'b1;
        end else if (div_done) begin
          step_x_d   = div_quo[COORD_W-1:0];
          launched_d = 1'b0;
          state_d    = S_STEPY;
        end
      end
      S_STEPY: begin
        mac_req.start = 1'b0;
        div_num = DIV_N_W'(dy);
        div_den = DIV_D_W'(cols_q - 1'b1);
        if (!ok_y || (launched_q && div_done)) begin
          step_y_d   = ok_y ? div_quo[COORD_W-1:0] : '0;
          launched_d = 1'b0;
          bw_d       = '0;
          state_d    = few ? S_OUT : S_NN;
        end else if (!launched_q) begin
          div_start  = 1'b1;
          launched_d = 1'b1;
        end
      end
      S_NN: begin
        mac_req.a   = MAC_A_W'(n);
        mac_req.b   = MAC_B_W'(n - 1'b1);
        mac_req.na  = 2'd1;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          den_d      = mac_acc[DIV_D_W-1:0];
          launched_d = 1'b0;
          state_d    = S_QX;
        end
      end
      S_QX, S_QY: begin
        mac_req.a   = MAC_A_W'(state_q == S_QX ? acc.sumsq_x : acc.sumsq_y);
        mac_req.b   = MAC_B_W'(n);
        mac_req.na  = 2'd2;
        mac_req.nb  = 2'd1;
        mac_req.clr = state_q == S_QX;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          launched_d = 1'b0;
          state_d    = state_q == S_QX ? S_SX : S_SY;
        end
      end
      S_SX, S_SY: begin
        mac_req.a   = MAC_A_W'(state_q == S_SX ? mag_sx : mag_sy);
        mac_req.b   = MAC_B_W'(state_q == S_SX ? mag_sx : mag_sy);
        mac_req.na  = 2'd2;
        mac_req.nb  = 2'd2;
        mac_req.sub = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          launched_d = 1'b0;
          state_d    = state_q == S_SX ? S_QY : S_VAR;
        end
      end
      S_VAR: begin
        mac_req.start = 1'b0;
        div_num = mac_acc[DIV_N_W-1:0];
        div_den = den_q;
        if (!launched_q) begin
          div_start  = 1'b1;
          launched_d = 1'b1;
        end else if (div_done) begin
          launched_d = 1'b0;
          state_d    = S_ROOT;
        end
      end
      S_ROOT: begin
        mac_req.start = 1'b0;
        if (!launched_q) begin
          sqrt_start = 1'b1;
          launched_d = 1'b1;
        end else if (sqrt_done) begin
          root_d     = sqrt_root;
          g_d        = '0;
          k_d        = G_K_W'(G_W - 1);
          launched_d = 1'b0;
          state_d    = S_P2;
        end
      end
      S_P2: begin
        mac_req.a   = MAC_A_W'(cand);
        mac_req.b   = MAC_B_W'(cand);
        mac_req.na  = 2'd1;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          p2_d       = mac_acc[LIMB_W-1:0];
          launched_d = 1'b0;
          state_d    = S_P4;
        end
      end
      S_P4: begin
        mac_req.a   = mac_acc[MAC_A_W-1:0];
        mac_req.b   = mac_acc[MAC_B_W-1:0];
        mac_req.na  = 2'd1;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          launched_d = 1'b0;
          state_d    = S_P6;
        end
      end
      S_P6: begin
        mac_req.a   = mac_acc[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(p2_q);
        mac_req.na  = 2'd2;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          launched_d = 1'b0;
          state_d    = S_PN;
        end
      end
      S_PN: begin
        mac_req.a   = mac_acc[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(n);
        mac_req.na  = 2'd3;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          if (pn_ok) g_d = cand;
          launched_d = 1'b0;
          if (k_q == '0) begin
            state_d = S_BW1;
          end else begin
            k_d     = k_q - 1'b1;
            state_d = S_P2;
          end
        end
      end
      S_BW1: begin
        mac_req.a   = MAC_A_W'(root_q);
        mac_req.b   = MAC_B_W'(scale_q);
        mac_req.na  = 2'd1;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          launched_d = 1'b0;
          state_d    = S_BW2;
        end
      end
      S_BW2: begin
        mac_req.a   = mac_acc[MAC_A_W-1:0];
        mac_req.b   = MAC_B_W'(g_q);
        mac_req.na  = 2'd2;
        mac_req.nb  = 2'd1;
        mac_req.clr = 1'b1;
        if (!launched_q) launched_d = 1'b1;
        else if (mac_done) begin
          bw_d       = bw_sat ? '1 : mac_acc[BW_SHIFT+BW_W-1:BW_SHIFT];
          launched_d = 1'b0;
          state_d    = S_OUT;
        end
      end
      S_OUT: begin
        mac_req.start = 1'b0;
        // The previous item must have left the output register.
        if (!out_valid_q || !out_stall_i) begin
          out_load             = 1'b1;
          acc_clr              = 1'b1;
          out_d.min_x          = acc.lo_x;
          out_d.max_x          = acc.hi_x;
          out_d.min_y          = acc.lo_y;
          out_d.max_y          = acc.hi_y;
          out_d.step_x         = step_x_q;
          out_d.step_y         = step_y_q;
          out_d.bandwidth      = bw_q;
          out_d.point_count    = n;
          out_d.too_few_points = few;
          state_d              = S_IDLE;
        end
      end
      default: begin
        mac_req.start = 1'b0;
        state_d       = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    step_x_q <= step_x_d;
    step_y_q <= step_y_d;
    den_q    <= den_d;
    g_q      <= g_d;
    k_q      <= k_d;
    p2_q     <= p2_d;
    root_q   <= root_d;
    bw_q     <= bw_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/core/pekb_accum.sv -----
// ----------------------------------------------------------------------------
// pekb_accum
// Running point count, bounding box, sums and sums of squares of one set.
// ----------------------------------------------------------------------------
module pekb_accum import pekb_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      upd_i,
  input  logic                      clr_i,
  input  logic signed [COORD_W-1:0] x_i,
  input  logic signed [COORD_W-1:0] y_i,
  output pekb_acc_t                 acc_o
);

  localparam pekb_acc_t ACC_RST = '{
    count: '0, lo_x: COORD_MAX, hi_x: COORD_MIN, lo_y: COORD_MAX, hi_y: COORD_MIN,
    sum_x: '0, sum_y: '0, sumsq_x: '0, sumsq_y: '0
  };

  pekb_acc_t                   acc_q, acc_d;
  logic signed [2*COORD_W-1:0] xx, yy;
  logic                        room;

  always_comb begin
    xx    = x_i * x_i;
    yy    = y_i * y_i;
    room  = acc_q.count < CNT_W'(MAX_POINTS);
    acc_d = acc_q;
    if (clr_i) begin
      acc_d = ACC_RST;
    end else if (upd_i && room) begin
      acc_d.count = acc_q.count + 1'b1;
      if (x_i < acc_q.lo_x) acc_d.lo_x = x_i;
      if (x_i > acc_q.hi_x) acc_d.hi_x = x_i;
      if (y_i < acc_q.lo_y) acc_d.lo_y = y_i;
      if (y_i > acc_q.hi_y) acc_d.hi_y = y_i;
      acc_d.sum_x   = acc_q.sum_x + SUM_W'(x_i);
      acc_d.sum_y   = acc_q.sum_y + SUM_W'(y_i);
      acc_d.sumsq_x = acc_q.sumsq_x + SQ_W'(unsigned'(xx));
      acc_d.sumsq_y = acc_q.sumsq_y + SQ_W'(unsigned'(yy));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= ACC_RST;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/core/pekb_mac.sv -----
// ----------------------------------------------------------------------------
// pekb_mac
// Shared multiply-accumulate unit: one 32x32 limb product per cycle,
// added to or subtracted from a 128-bit accumulator at the limb offset.
// ----------------------------------------------------------------------------
module pekb_mac import pekb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pekb_mac_req_t        req_i,
  output logic                 done_o,
  output logic [MAC_ACC_W-1:0] acc_o
);

  logic                 busy_q, done_q;
  logic [1:0]           i_q, j_q, na_q, nb_q;
  logic                 sub_q;
  logic [MAC_A_W-1:0]   a_q;
  logic [MAC_B_W-1:0]   b_q;
  logic [MAC_ACC_W-1:0] acc_q;

  logic [LIMB_W-1:0]    a_limb, b_limb;
  logic [2*LIMB_W-1:0]  prod;
  logic [1:0]           sh;
  logic [MAC_ACC_W-1:0] term;
  logic                 j_last, last_limb;

  always_comb begin
    a_limb    = LIMB_W'(a_q >> (LIMB_W * i_q));
    b_limb    = LIMB_W'(b_q >> (LIMB_W * j_q));
    prod      = a_limb * b_limb;
    sh        = i_q + j_q;
    term      = MAC_ACC_W'(prod) << (LIMB_W * sh);
    j_last    = j_q == nb_q - 2'd1;
    last_limb = j_last && (i_q == na_q - 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        i_q    <= '0;
        j_q    <= '0;
      end else if (busy_q) begin
        if (j_last) begin
          j_q <= '0;
          i_q <= i_q + 2'd1;
        end else begin
          j_q <= j_q + 2'd1;
        end
        if (last_limb) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      na_q  <= req_i.na;
      nb_q  <= req_i.nb;
      sub_q <= req_i.sub;
      if (req_i.clr) acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= sub_q ? acc_q - term : acc_q + term;
    end
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule

// ----- rtl/core/pekb_div.sv -----
// ----------------------------------------------------------------------------
// pekb_div
// Restoring divider, one quotient bit per cycle over the full numerator.
// ----------------------------------------------------------------------------
module pekb_div import pekb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DIV_N_W-1:0] num_i,
  input  logic [DIV_D_W-1:0] den_i,
  output logic               done_o,
  output logic [DIV_Q_W-1:0] quo_o
);

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_N_W-1:0]   num_q;
  logic [DIV_D_W-1:0]   den_q, rem_q;
  logic [DIV_Q_W-1:0]   quo_q;
  logic [DIV_D_W:0]     rem_sh, rem_nx;
  logic                 ge;

  always_comb begin
    rem_sh = {rem_q, num_q[DIV_N_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_q << 1;
      rem_q <= rem_nx[DIV_D_W-1:0];
      quo_q <= {quo_q[DIV_Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ----- rtl/core/pekb_sqrt.sv -----
// ----------------------------------------------------------------------------
// pekb_sqrt
// Integer square root by the digit-by-digit method, two radicand bits a cycle.
// ----------------------------------------------------------------------------
module pekb_sqrt import pekb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [ROOT_IN_W-1:0] val_i,
  output logic                 done_o,
  output logic [ROOT_W-1:0]    root_o
);

  logic                 busy_q, done_q;
  logic [ROOT_IN_W-1:0] v_q, res_q, bit_q, sum;
  logic                 ge;

  always_comb begin
    sum = res_q + bit_q;
    ge  = v_q >= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      res_q <= '0;
      bit_q <= ROOT_IN_W'(1) << (ROOT_IN_W - 2);
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - sum;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = res_q[ROOT_W-1:0];

endmodule

// ----- rtl/core/pekb_checker.sv -----
// ----------------------------------------------------------------------------
// pekb_checker
// Port-level checks on the result items of the extent and bandwidth block.
// ----------------------------------------------------------------------------
`include "point_extent_and_kde_bandwidth_defines.svh"

module pekb_checker import pekb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input pekb_out_t out_data_o
);

  `PEKB_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result item changed")

  `PEKB_ASSERT_IMP(a_few_flag, out_valid_o, out_data_o.too_few_points == (out_data_o.point_count < CNT_W'(2)), "too_few_points disagrees with point_count")

  `PEKB_ASSERT_IMP(a_few_bw, out_valid_o && out_data_o.too_few_points, out_data_o.bandwidth == '0, "bandwidth not zero for a small set")

  `PEKB_ASSERT_IMP(a_box_order, out_valid_o && (out_data_o.point_count != '0), (out_data_o.min_x <= out_data_o.max_x) && (out_data_o.min_y <= out_data_o.max_y), "bounding box inverted")

endmodule

bind point_extent_and_kde_bandwidth pekb_checker u_pekb_checker (.*);
